FILE: hdl/tuc_pkg.sv
// Package for the TCP/UDP checksum offload core: payload structs, status codes,
// frame offsets and protocol constants. No dependencies.
package tuc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 65535;

  // at most 65535 segment bytes taken as 16-bit words: the running sum stays below 2^32
  localparam int unsigned SUM_W = 32;

  localparam logic [15:0] IP_BASE      = 16'd14;
  localparam logic [15:0] POS_VER_IHL  = 16'd14;
  localparam logic [15:0] POS_TLEN_HI  = 16'd16;
  localparam logic [15:0] POS_TLEN_LO  = 16'd17;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_ADDR_LO  = 16'd26;
  localparam logic [15:0] POS_ADDR_HI  = 16'd33;
  localparam logic [15:0] MIN_LEN_VER  = 16'd15;
  localparam logic [15:0] MIN_LEN_PROT = 16'd24;

  localparam logic [7:0]  VER_MASK     = 8'hf0;
  localparam logic [7:0]  VER_IPV4     = 8'h40;
  localparam logic [3:0]  MIN_IHL      = 4'd5;

  localparam logic [7:0]  TCP_PROTO    = 8'd6;
  localparam logic [7:0]  UDP_PROTO    = 8'd17;
  localparam logic [4:0]  TCP_CK_OFF   = 5'd16;
  localparam logic [4:0]  UDP_CK_OFF   = 5'd6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_IPV4  = 3'd1,
    ST_BAD_PROTO = 3'd2,
    ST_SHORT     = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_BAD_IHL   = 3'd5
  } tuc_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tuc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] checksum;
    logic [15:0] checksum_position;
  } tuc_out_t;

  // per-frame running state
  typedef struct packed {
    logic [15:0]      byte_index;
    logic [3:0]       header_words;
    logic [15:0]      total_length;
    logic [7:0]       protocol_number;
    logic [SUM_W-1:0] sum;
    logic             version_bad;
  } tuc_frame_t;

  function automatic logic [4:0] ck_offset(input logic [7:0] proto);
    return (proto == UDP_PROTO) ? UDP_CK_OFF : TCP_CK_OFF;
  endfunction

endpackage

FILE: hdl/tuc_accum.sv
// Frame parser and running sum: tracks header fields and sums address and
// segment bytes one byte per step. Depends on tuc_pkg.
module tuc_accum #(
  parameter int unsigned MAX_FRAME_BYTES = tuc_pkg::MAX_FRAME_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tuc_pkg::tuc_in_t   byte_i,
  output tuc_pkg::tuc_frame_t frame_o
);

  tuc_pkg::tuc_frame_t frame_q, frame_d;

  logic [15:0] pos;
  logic [5:0]  hl;
  logic [15:0] start;
  logic [15:0] rel;
  logic [15:0] plen;
  logic [4:0]  off;
  logic        in_addr, in_seg;
  logic [15:0] addend;

  always_comb begin
    frame_d = frame_q;
    pos     = frame_q.byte_index;
    hl      = {frame_q.header_words, 2'b00};
    start   = tuc_pkg::IP_BASE + {10'd0, hl};
    rel     = pos - start;
    plen    = frame_q.total_length - {10'd0, hl};
    off     = tuc_pkg::ck_offset(frame_q.protocol_number);
    in_addr = (pos >= tuc_pkg::POS_ADDR_LO) && (pos <= tuc_pkg::POS_ADDR_HI);
    in_seg  = (frame_q.header_words >= tuc_pkg::MIN_IHL) && (pos >= start) &&
              (frame_q.total_length > {10'd0, hl}) && (rel < plen) &&
              (rel != {11'd0, off}) && (rel != {11'd0, off} + 16'd1);
    // words start on even frame offsets, so odd position means low byte
    addend  = pos[0] ? {8'd0, byte_i.data_byte} : {byte_i.data_byte, 8'd0};

    if (pos < 16'(MAX_FRAME_BYTES)) begin
      case (pos)
        tuc_pkg::POS_VER_IHL: begin
          frame_d.version_bad  = (byte_i.data_byte & tuc_pkg::VER_MASK) != tuc_pkg::VER_IPV4;
          frame_d.header_words = byte_i.data_byte[3:0];
        end
        tuc_pkg::POS_TLEN_HI: frame_d.total_length[15:8] = byte_i.data_byte;
        tuc_pkg::POS_TLEN_LO: frame_d.total_length[7:0]  = byte_i.data_byte;
        tuc_pkg::POS_PROTO:   frame_d.protocol_number    = byte_i.data_byte;
        default: ;
      endcase
      // address bytes and segment bytes never overlap
      if (in_addr || in_seg) begin
        frame_d.sum = frame_q.sum + {{(tuc_pkg::SUM_W-16){1'b0}}, addend};
      end
      frame_d.byte_index = pos + 16'd1;
    end
  end

  assign frame_o = frame_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (step_i) begin
      if (byte_i.last_byte) begin
        frame_q <= '0;
      end else begin
        frame_q <= frame_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && byte_i.last_byte |=> frame_q.byte_index == 16'd0 && frame_q.sum == '0)
    else $error("frame state not cleared after last byte");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(frame_q))
    else $error("frame state changed without a request");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !byte_i.last_byte && frame_q.byte_index < 16'(MAX_FRAME_BYTES)
    |=> frame_q.byte_index == $past(frame_q.byte_index) + 16'd1)
    else $error("byte index did not advance");

endmodule

FILE: hdl/tuc_final.sv
// End-of-frame evaluation: status checks, length fold and complement of the
// sum, checksum field position. Depends on tuc_pkg.
module tuc_final (
  input  tuc_pkg::tuc_frame_t frame_i,
  output tuc_pkg::tuc_out_t   result_o
);

  tuc_pkg::tuc_status_e status;
  logic [5:0]  hl;
  logic [4:0]  off;
  logic [15:0] seg_len;
  logic        proto_ok;
  logic [16:0] need_len;
  logic [tuc_pkg::SUM_W:0] total;
  logic [17:0] fold1;
  logic [16:0] fold2;
  logic [15:0] fold3;

  always_comb begin
    hl       = {frame_i.header_words, 2'b00};
    off      = tuc_pkg::ck_offset(frame_i.protocol_number);
    seg_len  = frame_i.total_length - {10'd0, hl};
    proto_ok = (frame_i.protocol_number == tuc_pkg::TCP_PROTO) ||
               (frame_i.protocol_number == tuc_pkg::UDP_PROTO);
    need_len = {1'b0, tuc_pkg::IP_BASE} + {1'b0, frame_i.total_length};

    if (frame_i.byte_index < tuc_pkg::MIN_LEN_VER) begin
      status = tuc_pkg::ST_TRUNC;
    end else if (frame_i.version_bad) begin
      status = tuc_pkg::ST_NOT_IPV4;
    end else if (frame_i.header_words < tuc_pkg::MIN_IHL) begin
      status = tuc_pkg::ST_BAD_IHL;
    end else if (frame_i.byte_index < tuc_pkg::MIN_LEN_PROT) begin
      status = tuc_pkg::ST_TRUNC;
    end else if (!proto_ok) begin
      status = tuc_pkg::ST_BAD_PROTO;
    end else if ((frame_i.total_length < {10'd0, hl}) ||
                 (seg_len < {11'd0, off} + 16'd2)) begin
      status = tuc_pkg::ST_SHORT;
    end else if ({1'b0, frame_i.byte_index} < need_len) begin
      status = tuc_pkg::ST_TRUNC;
    end else begin
      status = tuc_pkg::ST_OK;
    end

    // pseudo-header protocol and length, then three end-around folds
    total = {1'b0, frame_i.sum} + (tuc_pkg::SUM_W + 1)'(frame_i.protocol_number) +
            (tuc_pkg::SUM_W + 1)'(seg_len);
    fold1 = 18'(total[15:0]) + 18'(total[tuc_pkg::SUM_W:16]);
    fold2 = {1'b0, fold1[15:0]} + {15'd0, fold1[17:16]};
    fold3 = fold2[15:0] + {15'd0, fold2[16]};

    result_o.status = status;
    if (status == tuc_pkg::ST_OK) begin
      result_o.checksum          = ~fold3;
      result_o.checksum_position = tuc_pkg::IP_BASE + {10'd0, hl} + {11'd0, off};
    end else begin
      result_o.checksum          = 16'd0;
      result_o.checksum_position = 16'd0;
    end
  end

endmodule

FILE: hdl/tcp_udp_checksum_offload_core.sv
// IPv4 TCP/UDP checksum offload core, one frame byte per request.
// Throughput: one byte per cycle; input stalls only when a last byte meets an
// untaken result. A last byte goes through the input register, then the result
// register, before the result is valid. Reset is asynchronous, active low,
// and clears the frame state and both valid flags.
module tcp_udp_checksum_offload_core #(
  parameter int unsigned MAX_FRAME_BYTES = tuc_pkg::MAX_FRAME_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tuc_pkg::tuc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tuc_pkg::tuc_out_t out_data_o
);

  logic                s1_valid_q;
  tuc_pkg::tuc_in_t    s1_q;
  logic                s1_adv;
  logic                out_valid_q;
  tuc_pkg::tuc_out_t   out_q;
  tuc_pkg::tuc_frame_t frame;
  tuc_pkg::tuc_out_t   result;

  // only a last byte needs the result register free
  assign s1_adv     = s1_valid_q && (!s1_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  tuc_accum #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_q),
    .frame_o(frame)
  );

  tuc_final u_final (
    .frame_i (frame),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.last_byte && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("last byte advanced over an untaken result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != tuc_pkg::ST_OK
    |-> out_q.checksum == 16'd0 && out_q.checksum_position == 16'd0)
    else $error("error result carries checksum data");

  a_ok_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == tuc_pkg::ST_OK |-> out_q.checksum_position >= 16'd40)
    else $error("checksum position inside IP header");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_q.last_byte |=> out_valid_q)
    else $error("result not loaded after last byte");

endmodule
